@@ rtl/core/cen_pkg.sv @@
package cen_pkg;

  // Field widths fixed by the register map and the result format
  localparam int unsigned SiteCfgW   = 6;
  localparam int unsigned PosW       = 6;
  localparam int unsigned MaskOutW   = 32;
  localparam int unsigned OrdW       = 30;
  localparam int unsigned MaxResults = 32;
  localparam int unsigned CntW       = $clog2(MaxResults);

  localparam logic [SiteCfgW-1:0] NumSitesRst  = 6'd9;
  localparam logic [SiteCfgW-1:0] OnesCountRst = 6'd1;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_NUM_SITES  = 1'b0,
    CFG_ONES_COUNT = 1'b1
  } cfg_idx_e;

  // Command handed from the front end to the back end
  typedef enum logic [1:0] {
    CMD_EXHAUST = 2'd0,
    CMD_RESTART = 2'd1,
    CMD_ADVANCE = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [SiteCfgW-1:0] num_sites;
    logic [SiteCfgW-1:0] ones_count;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

@@ rtl/core/cen_if.sv @@
// Request channel: one restart-or-advance command per request
interface cen_req_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

// Result channel: one set bit of the current mask per result
interface cen_rsp_if import cen_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [PosW-1:0]     position;
  logic [MaskOutW-1:0] mask;
  logic [OrdW-1:0]     combo_index;
  logic                last;
  logic                exhausted;

  modport source (output valid, output position, output mask, output combo_index,
                  output last, output exhausted, input ready);
  modport sink (input valid, input position, input mask, input combo_index,
                input last, input exhausted, output ready);
endinterface

// Configuration write channel
interface cen_cfg_if import cen_pkg::*; ();
  logic                valid;
  logic                ready;
  cfg_idx_e            idx;
  logic [SiteCfgW-1:0] data;

  modport source (output valid, output idx, output data, input ready);
  modport sink (input valid, input idx, input data, output ready);
endinterface

@@ rtl/core/cen_front.sv @@
module cen_front import cen_pkg::*; #(
  parameter int unsigned MAX_SITES = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cen_req_if.sink    req_i,
  cen_cfg_if.sink    cfg_i,
  input  fifo_stat_t fifo_stat_i,
  output logic       push_o,
  output cmd_e       push_cmd_o,
  output cfg_t       cfg_o
);

  cfg_t cfg_q;
  logic started_q;
  logic invalid;

  // Configuration registers, always writable
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.num_sites  <= NumSitesRst;
      cfg_q.ones_count <= OnesCountRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.idx)
        CFG_NUM_SITES:  cfg_q.num_sites  <= cfg_i.data;
        CFG_ONES_COUNT: cfg_q.ones_count <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

  // Classify the configuration: no mask exists for these settings
  assign invalid = (cfg_q.num_sites == '0) || (cfg_q.ones_count == '0) ||
                   (cfg_q.ones_count > cfg_q.num_sites) ||
                   (32'(cfg_q.ones_count) > MAX_SITES);

  // Accept a request whenever the queue has room
  assign req_i.ready = !fifo_stat_i.full;
  assign push_o      = req_i.valid && req_i.ready;

  always_comb begin
    if (invalid) begin
      push_cmd_o = CMD_EXHAUST;
    end else if (req_i.restart || !started_q) begin
      push_cmd_o = CMD_RESTART;
    end else begin
      push_cmd_o = CMD_ADVANCE;
    end
  end

  // Track whether a valid request has opened the enumeration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
    end else if (push_o && !invalid) begin
      started_q <= 1'b1;
    end
  end

endmodule

@@ rtl/core/cen_cmd_fifo.sv @@
module cen_cmd_fifo import cen_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  cmd_e       push_cmd_i,
  input  logic       pop_i,
  output cmd_e       pop_cmd_o,
  output fifo_stat_t stat_o
);

  cmd_e       entry_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;

  // Write the entry at the write pointer
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  assign pop_cmd_o    = entry_q[rd_ptr_q];
  assign stat_o.full  = (count_q == 2'd2);
  assign stat_o.empty = (count_q == 2'd0);

endmodule

@@ rtl/core/cen_back.sv @@
module cen_back import cen_pkg::*; #(
  parameter int unsigned MAX_SITES = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  fifo_stat_t fifo_stat_i,
  input  cmd_e       pop_cmd_i,
  output logic       pop_o,
  cen_rsp_if.source  rsp_o
);

  localparam int unsigned IdxW = $clog2(MAX_SITES);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CALC1 = 6'b000010,
    S_CALC2 = 6'b000100,
    S_LOAD  = 6'b001000,
    S_EMIT  = 6'b010000,
    S_EXH   = 6'b100000
  } state_e;

  state_e               state_q, state_d;
  logic [MAX_SITES-1:0] mask_q, mask_d;
  logic [OrdW-1:0]      ord_q, ord_d;
  logic                 done_q, done_d;
  logic [MAX_SITES:0]   y_q, y_d;
  logic [MAX_SITES-1:0] run_q, run_d;
  logic [IdxW-1:0]      tx_q, tx_d;
  logic [MAX_SITES-1:0] rem_q, rem_d;
  logic [CntW-1:0]      cnt_q, cnt_d;

  logic                 out_valid_q, out_valid_d;
  logic [PosW-1:0]      out_pos_q, out_pos_d;
  logic [MaskOutW-1:0]  out_mask_q, out_mask_d;
  logic [OrdW-1:0]      out_ord_q, out_ord_d;
  logic                 out_last_q, out_last_d;
  logic                 out_exh_q, out_exh_d;

  logic [MAX_SITES-1:0] site_mask;
  logic [MAX_SITES-1:0] low_mask;
  logic [MAX_SITES-1:0] low_bit_x;
  logic [MAX_SITES-1:0] run_x;
  logic [MAX_SITES:0]   y_x;
  logic [MAX_SITES-1:0] nxt;
  logic                 ovf;
  logic [IdxW-1:0]      emit_idx;
  logic [IdxW:0]        emit_pos;
  logic [MAX_SITES-1:0] rem_nxt;
  logic                 emit_last;
  logic                 slot_free;

  // Index of the lowest set bit
  function automatic logic [IdxW-1:0] low_bit(input logic [MAX_SITES-1:0] v);
    logic [IdxW-1:0] r;
    r = '0;
    for (int i = MAX_SITES - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = IdxW'(i);
      end
    end
    return r;
  endfunction

  // Sites in range and the lowest mask for the current configuration
  always_comb begin
    for (int b = 0; b < MAX_SITES; b++) begin
      site_mask[b] = (b < int'(cfg_i.num_sites));
      low_mask[b]  = (b < int'(cfg_i.ones_count));
    end
  end

  // First half of the step: add the lowest set bit, isolate the low run
  assign low_bit_x = mask_q & (~mask_q + 1'b1);
  assign y_x       = {1'b0, mask_q} + {1'b0, low_bit_x};
  assign run_x     = mask_q & ~y_x[MAX_SITES-1:0];

  // Second half: refill the low bits, check for carry past the sites
  assign nxt = y_q[MAX_SITES-1:0] | ((run_q >> tx_q) >> 1);
  assign ovf = y_q[MAX_SITES] || ((nxt & ~site_mask) != '0);

  // Pick the next set bit to report
  assign emit_idx  = low_bit(rem_q);
  assign emit_pos  = {1'b0, emit_idx} + (IdxW + 1)'(1);
  assign rem_nxt   = rem_q & (rem_q - 1'b1);
  assign emit_last = (rem_nxt == '0) || (cnt_q == CntW'(MaxResults - 1));

  assign slot_free = !out_valid_q || rsp_o.ready;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    mask_d      = mask_q;
    ord_d       = ord_q;
    done_d      = done_q;
    y_d         = y_q;
    run_d       = run_q;
    tx_d        = tx_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    pop_o       = 1'b0;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_pos_d   = out_pos_q;
    out_mask_d  = out_mask_q;
    out_ord_d   = out_ord_q;
    out_last_d  = out_last_q;
    out_exh_d   = out_exh_q;

    case (state_q)
      S_IDLE: begin
        if (!fifo_stat_i.empty) begin
          pop_o = 1'b1;
          case (pop_cmd_i)
            CMD_RESTART: begin
              mask_d  = low_mask;
              ord_d   = '0;
              done_d  = 1'b0;
              state_d = S_LOAD;
            end
            CMD_ADVANCE: begin
              state_d = done_q ? S_EXH : S_CALC1;
            end
            default: begin
              state_d = S_EXH;
            end
          endcase
        end
      end
      S_CALC1: begin
        y_d   = y_x;
        run_d = run_x;
        tx_d  = low_bit(mask_q);
        if (mask_q == '0) begin
          done_d  = 1'b1;
          state_d = S_EXH;
        end else begin
          state_d = S_CALC2;
        end
      end
      S_CALC2: begin
        if (ovf) begin
          done_d  = 1'b1;
          state_d = S_EXH;
        end else begin
          mask_d  = nxt;
          ord_d   = ord_q + 1'b1;
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        rem_d   = mask_q & site_mask;
        cnt_d   = '0;
        state_d = ((mask_q & site_mask) == '0) ? S_EXH : S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_pos_d   = PosW'(emit_pos);
          out_mask_d  = MaskOutW'(mask_q);
          out_ord_d   = ord_q;
          out_last_d  = emit_last;
          out_exh_d   = 1'b0;
          rem_d       = rem_nxt;
          cnt_d       = cnt_q + 1'b1;
          if (emit_last) begin
            state_d = S_IDLE;
          end
        end
      end
      S_EXH: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_pos_d   = '0;
          out_mask_d  = '0;
          out_ord_d   = '0;
          out_last_d  = 1'b1;
          out_exh_d   = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control and enumeration state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mask_q      <= '0;
      ord_q       <= '0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mask_q      <= mask_d;
      ord_q       <= ord_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Step and result payload
  always_ff @(posedge clk_i) begin
    y_q        <= y_d;
    run_q      <= run_d;
    tx_q       <= tx_d;
    rem_q      <= rem_d;
    cnt_q      <= cnt_d;
    out_pos_q  <= out_pos_d;
    out_mask_q <= out_mask_d;
    out_ord_q  <= out_ord_d;
    out_last_q <= out_last_d;
    out_exh_q  <= out_exh_d;
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.position    = out_pos_q;
  assign rsp_o.mask        = out_mask_q;
  assign rsp_o.combo_index = out_ord_q;
  assign rsp_o.last        = out_last_q;
  assign rsp_o.exhausted   = out_exh_q;

endmodule

@@ rtl/core/combination_enumerator_core.sv @@
// Combination enumerator: steps through every mask of num_sites bits with
// ones_count bits set, in increasing numeric order.
// Channels: req_i takes one request (restart = 1 goes back to the lowest
// mask, 0 advances); rsp_o returns one result per set bit of the current
// mask in ascending site order, last marking the final one, or a single
// exhausted result when no mask is left or the configuration is invalid.
// cfg_i writes num_sites (index 0) and ones_count (index 1); write only
// while the block is idle.
// Timing: a front end takes requests into a two-entry command queue; the
// back-end sequencer emits one result per cycle while the result slot is
// free. A restart steps through S_IDLE, S_LOAD and S_EMIT; an advance
// through S_IDLE, S_CALC1 and S_CALC2 (the next-mask step), S_LOAD and
// S_EMIT, with at most 32 results reported per mask; exhausted answers
// leave from S_EXH.
// Reset: num_sites 9, ones_count 1, enumeration cleared; the first valid
// request restarts whatever its restart bit says.
// Stall: a held result stops the sequencer; the queue keeps taking up to
// two requests, after which req_i.ready drops.
module combination_enumerator_core import cen_pkg::*; #(
  parameter int unsigned MAX_SITES = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cen_req_if.sink   req_i,
  cen_rsp_if.source rsp_o,
  cen_cfg_if.sink   cfg_i
);

  cfg_t       cfg;
  fifo_stat_t fifo_stat;
  logic       push;
  cmd_e       push_cmd;
  logic       pop;
  cmd_e       pop_cmd;

  cen_front #(
    .MAX_SITES(MAX_SITES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .cfg_i      (cfg_i),
    .fifo_stat_i(fifo_stat),
    .push_o     (push),
    .push_cmd_o (push_cmd),
    .cfg_o      (cfg)
  );

  cen_cmd_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_cmd_i(push_cmd),
    .pop_i     (pop),
    .pop_cmd_o (pop_cmd),
    .stat_o    (fifo_stat)
  );

  cen_back #(
    .MAX_SITES(MAX_SITES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .fifo_stat_i(fifo_stat),
    .pop_cmd_i  (pop_cmd),
    .pop_o      (pop),
    .rsp_o      (rsp_o)
  );

  // Queue never overrun nor read empty
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !fifo_stat.full)
    else $error("command pushed into a full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> !fifo_stat.empty)
    else $error("command popped from an empty queue");

  // An exhausted result stands alone with zeroed fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.exhausted) |->
      (rsp_o.last && (rsp_o.position == '0) && (rsp_o.mask == '0) &&
       (rsp_o.combo_index == '0)))
    else $error("malformed exhausted result");

endmodule
